// ===== sv/acd_pkg.sv =====
// package for the aliquot cycle detector
// constants and field widths shared by all modules, no dependencies
package acd_pkg;
    localparam int VAL_W        = 24;
    localparam int SUM_W        = 32;
    localparam int LEN_W        = 6;
    localparam int CNT_W        = 24;
    localparam int IDX_W        = 1;
    localparam int MEMBER_DEPTH_DEF = 64;
    localparam logic [VAL_W-1:0] MAXV_RESET   = 24'd10000000;
    localparam logic [LEN_W-1:0] MAXLEN_RESET = 6'd28;
    localparam logic [CNT_W-1:0] CNT_MAX      = '1;
    localparam logic [IDX_W-1:0] REG_MAX_VALUE = 1'b0;
    localparam logic [IDX_W-1:0] REG_MAX_LEN   = 1'b1;
endpackage

// ===== sv/acd_divsum.sv =====
// aliquot sum unit: trial division with a shared restoring divider
// one quotient bit per cycle; depends on acd_pkg
module acd_divsum
    import acd_pkg::*;
(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_start,
    input  logic [SUM_W-1:0] i_value,
    output logic             o_done,
    output logic [SUM_W-1:0] o_sum
);
    typedef enum logic [3:0] {
        S_IDLE = 4'b0001,
        S_CHK  = 4'b0010,
        S_DIV  = 4'b0100,
        S_ACC  = 4'b1000
    } t_state;

    t_state           r_state, n_state;
    logic [SUM_W-1:0] r_v, n_v;
    logic [15:0]      r_d, n_d;
    logic [33:0]      r_sum, n_sum;
    logic [SUM_W-1:0] r_q, n_q;
    logic [SUM_W:0]   r_rem, n_rem;
    logic [5:0]       r_bit, n_bit;
    logic [31:0]      r_sq, n_sq;
    logic             r_done, n_done;
    logic [SUM_W:0]   w_trial;

    assign w_trial = {r_rem[SUM_W-1:0], r_v[r_bit[4:0]]} - {17'd0, r_d};

    always_comb begin
        n_state = r_state; n_v = r_v; n_d = r_d; n_sum = r_sum; n_q = r_q;
        n_rem = r_rem; n_bit = r_bit; n_sq = r_sq; n_done = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    n_v = i_value; n_d = 16'd2; n_sq = 32'd4; n_sum = 34'd1;
                    n_state = S_CHK;
                end
            end
            S_CHK: begin
                if ({1'b0, r_sq} > {1'b0, r_v} || r_d == 16'hFFFF && r_sq > r_v) begin
                    n_done = 1'b1; n_state = S_IDLE;
                end else begin
                    n_rem = '0; n_q = '0; n_bit = 6'd31; n_state = S_DIV;
                end
            end
            S_DIV: begin
                if (!w_trial[SUM_W]) begin
                    n_rem = w_trial;
                    n_q = {r_q[SUM_W-2:0], 1'b1};
                end else begin
                    n_rem = {r_rem[SUM_W-1:0], r_v[r_bit[4:0]]};
                    n_q = {r_q[SUM_W-2:0], 1'b0};
                end
                if (r_bit == 6'd0) n_state = S_ACC;
                n_bit = r_bit - 6'd1;
            end
            S_ACC: begin
                if (r_rem == '0) begin
                    n_sum = r_sum + {18'd0, r_d}
                          + ((r_q != {16'd0, r_d}) ? {2'd0, r_q} : 34'd0);
                end
                n_sq = r_sq + {15'd0, r_d, 1'b0} + 32'd1;
                n_d = r_d + 16'd1;
                n_state = (r_d == 16'hFFFF) ? S_IDLE : S_CHK;
                n_done = (r_d == 16'hFFFF);
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_done <= 1'b0;
        end else begin
            r_state <= n_state;
            r_done <= n_done;
        end
        r_v <= n_v; r_d <= n_d; r_sum <= n_sum; r_q <= n_q;
        r_rem <= n_rem; r_bit <= n_bit; r_sq <= n_sq;
    end

    assign o_done = r_done;
    assign o_sum  = r_sum[SUM_W-1:0];
endmodule

// ===== sv/aliquot_cycle_detector.sv =====
// aliquot cycle detector top level
// walks aliquot sequences with acd_divsum; depends on acd_pkg
//
// usage:
//   input channel: one start_value per beat; ready only while idle
//   config channel: index 0 max_value, 1 max_cycle_length; write while idle
//   output channel: one beat per cycle member (s(n) first, n last), or one
//     not-found beat; last marks the final beat of an item
// walk: each aliquot sum of v tries up to sqrt(v) trial divisors in the shared divider,
//   and the step count is bounded by one more than the lesser of max_cycle_length
//   and MEMBER_DEPTH - 1
// output: each beat is read from member memory in S_READ and shown in S_EMIT; a stall
//   holds the beat and the block waits
// reset: counts clear, registers take 10000000 and 28, block goes idle;
//   no clearing pass is needed
// throughput: one item at a time, set by the shared divider loop
module aliquot_cycle_detector
    import acd_pkg::*;
#(
    parameter int MEMBER_DEPTH = MEMBER_DEPTH_DEF
)(
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  logic [VAL_W-1:0] i_start_value,
    input  logic             i_cfg_valid,
    output logic             o_cfg_ready,
    input  logic [IDX_W-1:0] i_cfg_index,
    input  logic [VAL_W-1:0] i_cfg_data,
    output logic             o_out_valid,
    input  logic             i_out_ready,
    output logic             o_found,
    output logic [6:0]       o_cycle_length,
    output logic [5:0]       o_member_index,
    output logic [SUM_W-1:0] o_member_value,
    output logic             o_last,
    output logic [CNT_W-1:0] o_total_cycles,
    output logic [CNT_W-1:0] o_perfect_count,
    output logic [CNT_W-1:0] o_amicable_count
);
    localparam int AW = $clog2(MEMBER_DEPTH);
    localparam logic [LEN_W-1:0] LIM_CAP = LEN_W'(MEMBER_DEPTH - 1);

    typedef enum logic [5:0] {
        S_IDLE = 6'b000001,
        S_WAIT = 6'b000010,
        S_TEST = 6'b000100,
        S_READ = 6'b001000,
        S_EMIT = 6'b010000,
        S_MISS = 6'b100000
    } t_state;

    t_state             r_state;
    logic [VAL_W-1:0]   r_maxv;
    logic [LEN_W-1:0]   r_maxlen;
    logic [VAL_W-1:0]   r_n;
    logic [SUM_W-1:0]   r_cur;
    logic [6:0]         r_steps;
    logic [6:0]         r_k;
    logic [CNT_W-1:0]   r_tot, r_perf, r_ami;
    logic [SUM_W-1:0]   r_mem [MEMBER_DEPTH];
    logic [SUM_W-1:0]   r_rd;
    logic               r_start;
    logic [SUM_W-1:0]   r_dval;
    logic               w_done;
    logic [SUM_W-1:0]   w_sum;
    logic [LEN_W-1:0]   w_lim;

    assign w_lim = (r_maxlen > LIM_CAP) ? LIM_CAP : r_maxlen;

    acd_divsum u_divsum (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_start(r_start),
        .i_value(r_dval), .o_done(w_done), .o_sum(w_sum)
    );

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_out_valid = (r_state == S_EMIT) || (r_state == S_MISS);
    assign o_found        = (r_state == S_EMIT);
    assign o_cycle_length = (r_state == S_EMIT) ? r_steps : 7'd0;
    assign o_member_index = (r_state == S_EMIT) ? r_k[5:0] : 6'd0;
    assign o_member_value = (r_state == S_EMIT) ? r_rd : '0;
    assign o_last = (r_state == S_MISS) || (r_k + 7'd1 == r_steps);
    assign o_total_cycles   = r_tot;
    assign o_perfect_count  = r_perf;
    assign o_amicable_count = r_ami;

    always_ff @(posedge i_clk) begin
        if (r_state == S_WAIT && w_done)
            r_mem[AW'(r_steps - 7'd1)] <= w_sum;
        r_rd <= r_mem[AW'(r_k)];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_maxv <= MAXV_RESET; r_maxlen <= MAXLEN_RESET;
            r_tot <= '0; r_perf <= '0; r_ami <= '0;
            r_start <= 1'b0;
        end else begin
            r_start <= 1'b0;
            case (r_state)
                S_IDLE: begin
                    if (i_cfg_valid) begin
                        if (i_cfg_index == REG_MAX_VALUE) r_maxv <= i_cfg_data;
                        else r_maxlen <= i_cfg_data[LEN_W-1:0];
                    end
                    if (i_in_valid) begin
                        r_n <= i_start_value;
                        r_steps <= 7'd1;
                        r_k <= '0;
                        if (i_start_value < VAL_W'(2)) begin
                            r_state <= S_MISS;
                        end else begin
                            r_dval <= {8'd0, i_start_value};
                            r_start <= 1'b1;
                            r_state <= S_WAIT;
                        end
                    end
                end
                S_WAIT: begin
                    if (w_done) begin
                        r_cur <= w_sum;
                        r_state <= S_TEST;
                    end
                end
                S_TEST: begin
                    if (r_cur > {8'd0, r_n} && !(r_cur > {8'd0, r_maxv} || r_cur <= 32'd1
                                  || r_steps > {1'b0, w_lim})) begin
                        r_dval <= r_cur;
                        r_start <= 1'b1;
                        r_steps <= r_steps + 7'd1;
                        r_state <= S_WAIT;
                    end else if (r_cur == {8'd0, r_n}) begin
                        if (r_steps == 7'd1 && r_perf != CNT_MAX) r_perf <= r_perf + 1'b1;
                        if (r_steps == 7'd2 && r_ami != CNT_MAX) r_ami <= r_ami + 1'b1;
                        if (r_tot != CNT_MAX) r_tot <= r_tot + 1'b1;
                        r_state <= S_READ;
                    end else begin
                        r_state <= S_MISS;
                    end
                end
                S_READ: r_state <= S_EMIT;
                S_EMIT: begin
                    if (i_out_ready) begin
                        r_k <= r_k + 7'd1;
                        r_state <= (r_k + 7'd1 == r_steps) ? S_IDLE : S_READ;
                    end
                end
                S_MISS: if (i_out_ready) r_state <= S_IDLE;
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule

// ===== sv/acd_checker.sv =====
// port-level checks for the aliquot cycle detector
// bound to aliquot_cycle_detector; depends on acd_pkg
module acd_checker
    import acd_pkg::*;
(
    input logic             i_clk,
    input logic             i_rst_n,
    input logic             o_in_ready,
    input logic             o_out_valid,
    input logic             i_out_ready,
    input logic             o_found,
    input logic [6:0]       o_cycle_length,
    input logic [5:0]       o_member_index,
    input logic             o_last,
    input logic [CNT_W-1:0] o_total_cycles
);
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> !o_in_ready) else $error("ready during output");
    a_miss_shape: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !o_found) |-> (o_last && o_cycle_length == 7'd0))
        else $error("bad not-found beat");
    a_last_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && o_found && o_last) |->
        ({1'b0, o_member_index} + 7'd1 == o_cycle_length)) else $error("bad last");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=>
        (o_out_valid && $stable(o_found) && $stable(o_member_index)))
        else $error("beat dropped during stall");
    a_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && $past(o_in_ready)) |-> $stable(o_total_cycles))
        else $error("count moved while idle");
endmodule

bind aliquot_cycle_detector acd_checker u_acd_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n),
    .o_in_ready(o_in_ready), .o_out_valid(o_out_valid), .i_out_ready(i_out_ready),
    .o_found(o_found), .o_cycle_length(o_cycle_length),
    .o_member_index(o_member_index), .o_last(o_last),
    .o_total_cycles(o_total_cycles)
);
